[hw/rtl/gcdr_pkg.sv]
// Shared constants, micro-op codes, command/status types and tables for the
// great-circle dead reckoning core. No dependencies.
package gcdr_pkg;

	localparam int SPHERE_RADIUS_M_DEF = 6371000;
	localparam int CORDIC_STEPS_DEF    = 24;
	localparam int HALF_TURN_DEG       = 180;

	// 2*pi in Q30
	localparam logic [63:0]        TWO_PI_Q30 = 64'd6746518852;
	localparam logic signed [35:0] GAIN_Q30   = 36'sd652032874;
	localparam logic signed [35:0] ONE_Q30    = 36'sd1073741824;
	localparam logic signed [35:0] LAT_LIMIT  = 36'sd754974720;

	// degrees (2^-23) to turns (2^32): floor((128*v + 45) / 90)
	localparam int                 TURN_DIV   = HALF_TURN_DEG / 2;
	localparam logic signed [41:0] TURN_BIAS  = 42'(HALF_TURN_DEG / 4);
	localparam logic signed [33:0] TURN_DEG   = 34'(2 * HALF_TURN_DEG);

	// Constant divides by reciprocal multiply: floor(a / d) is bits
	// [RECIP_SHIFT+31:RECIP_SHIFT] of a * ceil(2^RECIP_SHIFT / d), exact
	// while a * d stays at or below 2^RECIP_SHIFT.
	localparam int           RECIP_SHIFT = 99;
	// distance numerator is the speed-time product scaled by 2^22 * 2^32
	localparam int           DIST_SHIFT  = 54;
	localparam logic [127:0] TURN_RECIP  =
		((128'd1 << RECIP_SHIFT) + 128'(TURN_DIV - 1)) / 128'(TURN_DIV);

	typedef logic [4:0] uop_t;

	localparam uop_t U_M_DIST   = 5'd0;
	localparam uop_t U_DIV_DIST = 5'd1;
	localparam uop_t U_DIV_TLAT = 5'd2;
	localparam uop_t U_DIV_TLON = 5'd3;
	localparam uop_t U_COR_LAT  = 5'd4;
	localparam uop_t U_COR_D    = 5'd5;
	localparam uop_t U_COR_H    = 5'd6;
	localparam uop_t U_M_T1     = 5'd7;
	localparam uop_t U_M_T2     = 5'd8;
	localparam uop_t U_M_S2     = 5'd9;
	localparam uop_t U_M_SQ     = 5'd10;
	localparam uop_t U_SQRT     = 5'd11;
	localparam uop_t U_VEC_LAT  = 5'd12;
	localparam uop_t U_M_LAT    = 5'd13;
	localparam uop_t U_M_T3     = 5'd14;
	localparam uop_t U_M_Y      = 5'd15;
	localparam uop_t U_M_X      = 5'd16;
	localparam uop_t U_VEC_LON  = 5'd17;
	localparam uop_t U_M_LON    = 5'd18;
	localparam uop_t U_M_ALT    = 5'd19;

	localparam logic [4:0] PROG_LAST = 5'd19;

	typedef struct packed {
		logic capture;
		logic start;
		uop_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic load;
		logic done;
	} dp_stat_t;

	// Advance program: one micro-op per slot, executed in order.
	function automatic uop_t prog(input logic [4:0] pc);
		uop_t op;
		unique case (pc)
			5'd0:    op = U_M_DIST;
			5'd1:    op = U_DIV_DIST;
			5'd2:    op = U_DIV_TLAT;
			5'd3:    op = U_DIV_TLON;
			5'd4:    op = U_COR_LAT;
			5'd5:    op = U_COR_D;
			5'd6:    op = U_COR_H;
			5'd7:    op = U_M_T1;
			5'd8:    op = U_M_T2;
			5'd9:    op = U_M_S2;
			5'd10:   op = U_M_SQ;
			5'd11:   op = U_SQRT;
			5'd12:   op = U_VEC_LAT;
			5'd13:   op = U_M_LAT;
			5'd14:   op = U_M_T3;
			5'd15:   op = U_M_Y;
			5'd16:   op = U_M_X;
			5'd17:   op = U_VEC_LON;
			5'd18:   op = U_M_LON;
			default: op = U_M_ALT;
		endcase
		return op;
	endfunction

	// atan(2^-i) in turns, 2^32 per turn
	function automatic logic [31:0] arc_turn(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			5'd31: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

[hw/rtl/gcdr_if.sv]
// Request and response channel interfaces of the dead reckoning core.
// Depends on nothing.
interface gcdr_req_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [23:0] ground_speed;
	logic signed [23:0] vertical_speed;
	logic [15:0]        heading;
	logic [15:0]        elapsed_seconds;
	logic signed [30:0] set_latitude;
	logic signed [31:0] set_longitude;
	logic signed [31:0] set_altitude;

	modport source (output valid, action, ground_speed, vertical_speed, heading,
		elapsed_seconds, set_latitude, set_longitude, set_altitude, input ready);
	modport sink (input valid, action, ground_speed, vertical_speed, heading,
		elapsed_seconds, set_latitude, set_longitude, set_altitude, output ready);
endinterface

interface gcdr_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic signed [31:0] altitude;

	modport source (output valid, latitude, longitude, altitude, input ready);
	modport sink (input valid, latitude, longitude, altitude, output ready);
endinterface

[hw/rtl/great_circle_dead_reckoning_core.sv]
// Great-circle dead reckoning core: a load request goes from accept through the decode
// state to response valid; an advance request also runs the micro-op program, mostly
// spent in the CORDIC loop, the square root and the three divides.
// One request is in flight at a time; the next is accepted after the response is taken.
// arst_n clears the position to zero and returns the controller to idle.
// Depends on gcdr_pkg, gcdr_if, gcdr_ctrl, gcdr_dp.
module great_circle_dead_reckoning_core #(
	parameter int SPHERE_RADIUS_M = gcdr_pkg::SPHERE_RADIUS_M_DEF,
	parameter int CORDIC_STEPS    = gcdr_pkg::CORDIC_STEPS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gcdr_req_if.sink   req,
	gcdr_rsp_if.source rsp
);

	// Command and status between sequencer and datapath.
	gcdr_pkg::dp_cmd_t  cmd;
	gcdr_pkg::dp_stat_t stat;

	// Sequencer: accept a request, run the advance program op by op for an
	// advance (each op waits for its unit's done), then hold the response.
	gcdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath: position registers drive the response payload directly;
	// they only change while a request is being worked on.
	gcdr_dp #(
		.SPHERE_RADIUS_M (SPHERE_RADIUS_M),
		.CORDIC_STEPS    (CORDIC_STEPS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (req.action),
		.ground_speed    (req.ground_speed),
		.vertical_speed  (req.vertical_speed),
		.heading         (req.heading),
		.elapsed_seconds (req.elapsed_seconds),
		.set_latitude    (req.set_latitude),
		.set_longitude   (req.set_longitude),
		.set_altitude    (req.set_altitude),
		.latitude        (rsp.latitude),
		.longitude       (rsp.longitude),
		.altitude        (rsp.altitude)
	);

endmodule

[hw/rtl/gcdr_div.sv]
// Constant divider by reciprocal multiplication: one 32x32 partial product a
// cycle per limb pair, low 32 quotient bits kept. Depends on gcdr_pkg.
module gcdr_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [38:0]  operand,
	input  logic [127:0] recip,
	output logic [31:0]  quo,
	output logic         done
);

	logic [63:0]  a_q;
	logic [127:0] r_q;
	logic [159:0] acc_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [31:0]  a_limb;
	logic [31:0]  r_limb;
	logic [63:0]  pp;
	logic [2:0]   limb_pos;
	logic [7:0]   sh;

	// walk operand limbs (outer) against reciprocal limbs (inner)
	assign a_limb   = cnt_q[2] ? a_q[63:32] : a_q[31:0];
	assign r_limb   = r_q[{cnt_q[1:0], 5'b0} +: 32];
	assign pp       = a_limb * r_limb;
	assign limb_pos = {1'b0, cnt_q[1:0]} + {2'b0, cnt_q[2]};
	assign sh       = {limb_pos, 5'b0};
	assign quo      = acc_q[gcdr_pkg::RECIP_SHIFT +: 32];
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= {25'b0, operand};
			r_q   <= recip;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + ({96'b0, pp} << sh);
		end
	end

endmodule

[hw/rtl/gcdr_cordic.sv]
// Shared iterative CORDIC: rotation mode gives sin/cos, vectoring gives atan2.
// Depends on gcdr_pkg.
module gcdr_cordic #(
	parameter int STEPS = gcdr_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               vec,
	input  logic [31:0]        ang,
	input  logic signed [35:0] xin,
	input  logic signed [35:0] yin,
	output logic signed [35:0] sin_o,
	output logic signed [35:0] cos_o,
	output logic [31:0]        angle,
	output logic               done
);

	localparam int CW = $clog2(STEPS);

	logic signed [35:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [31:0]        base_q;
	logic               flip_q, vec_q, busy_q, done_q;
	logic [CW-1:0]      cnt_q;

	logic signed [33:0] z_in, z_alt;
	logic               wide;
	logic signed [35:0] dx, dy;
	logic signed [33:0] a;
	logic               pos;

	assign z_in  = {{2{ang[31]}}, ang};
	assign z_alt = {{2{~ang[31]}}, ~ang[31], ang[30:0]};
	assign wide  = (z_in > 34'(gcdr_pkg::ONE_Q30)) || (z_in < -34'(gcdr_pkg::ONE_Q30));
	assign dx    = y_q >>> cnt_q;
	assign dy    = x_q >>> cnt_q;
	assign a     = 34'(gcdr_pkg::arc_turn(5'(cnt_q)));
	assign pos   = vec_q ? (y_q <= 36'sd0) : (z_q >= 34'sd0);

	assign sin_o = flip_q ? -y_q : y_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign angle = base_q + z_q[31:0];
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q <= vec;
			if (vec) begin
				flip_q <= 1'b0;
				z_q    <= '0;
				if (xin < 36'sd0) begin
					x_q    <= -xin;
					y_q    <= -yin;
					base_q <= 32'h8000_0000;
				end else begin
					x_q    <= xin;
					y_q    <= yin;
					base_q <= '0;
				end
			end else begin
				// fold angles beyond a quarter turn and negate the result
				x_q    <= gcdr_pkg::GAIN_Q30;
				y_q    <= '0;
				base_q <= '0;
				flip_q <= wide;
				z_q    <= wide ? z_alt : z_in;
			end
		end else if (busy_q) begin
			if (pos) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + a;
			end
		end
	end

endmodule

[hw/rtl/gcdr_dp.sv]
// Datapath: position state, item registers, multiplier, square root and the
// divider and CORDIC units. Depends on gcdr_pkg, gcdr_div, gcdr_cordic.
module gcdr_dp #(
	parameter int SPHERE_RADIUS_M = gcdr_pkg::SPHERE_RADIUS_M_DEF,
	parameter int CORDIC_STEPS    = gcdr_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gcdr_pkg::dp_cmd_t   cmd,
	output gcdr_pkg::dp_stat_t  stat,
	input  logic                action,
	input  logic signed [23:0]  ground_speed,
	input  logic signed [23:0]  vertical_speed,
	input  logic [15:0]         heading,
	input  logic [15:0]         elapsed_seconds,
	input  logic signed [30:0]  set_latitude,
	input  logic signed [31:0]  set_longitude,
	input  logic signed [31:0]  set_altitude,
	output logic signed [30:0]  latitude,
	output logic signed [31:0]  longitude,
	output logic signed [31:0]  altitude
);

	localparam logic [63:0] DEN_W = gcdr_pkg::TWO_PI_Q30 * 64'(SPHERE_RADIUS_M);
	// ceil(2^(DIST_SHIFT+RECIP_SHIFT) / DEN): exact for every speed-time product
	localparam logic [191:0] DIST_RECIP_W =
		((192'd1 << (gcdr_pkg::DIST_SHIFT + gcdr_pkg::RECIP_SHIFT))
		+ 192'(DEN_W) - 192'd1) / 192'(DEN_W);
	localparam logic [127:0] DIST_RECIP = DIST_RECIP_W[127:0];

	logic signed [30:0] pos_lat_q;
	logic signed [31:0] pos_lon_q, pos_alt_q;
	logic               action_q;
	logic signed [23:0] gs_q, vs_q;
	logic [15:0]        hd_q, el_q;
	logic [38:0]        dist_q;
	logic [31:0]        delta_q, tlat_q, tlon_q, latang_q, nl_q;
	logic signed [33:0] s1_q, c1_q, sd_q, cd_q, st_q, ct_q;
	logic signed [33:0] t1_q, t2_q, t3_q, s2_q, c2_q, yv_q, xv_q;
	logic [60:0]        sqv_q;
	logic               div_neg_q;

	logic               is_mul, is_div, is_cor;
	logic               mul_done_q;
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_s1;

	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		is_cor = 1'b0;
		unique case (cmd.op)
			gcdr_pkg::U_DIV_DIST, gcdr_pkg::U_DIV_TLAT, gcdr_pkg::U_DIV_TLON: is_div = 1'b1;
			gcdr_pkg::U_COR_LAT, gcdr_pkg::U_COR_D, gcdr_pkg::U_COR_H,
			gcdr_pkg::U_VEC_LAT, gcdr_pkg::U_VEC_LON: is_cor = 1'b1;
			gcdr_pkg::U_SQRT: ;
			default: is_mul = 1'b1;
		endcase
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			gcdr_pkg::U_M_DIST: begin
				mul_a = 34'(gs_q[23] ? -25'(gs_q) : 25'(gs_q));
				mul_b = {18'b0, el_q};
			end
			gcdr_pkg::U_M_T1:  begin mul_a = s1_q; mul_b = cd_q; end
			gcdr_pkg::U_M_T2:  begin mul_a = c1_q; mul_b = sd_q; end
			gcdr_pkg::U_M_S2:  begin mul_a = t2_q; mul_b = ct_q; end
			gcdr_pkg::U_M_SQ:  begin mul_a = s2_q; mul_b = s2_q; end
			gcdr_pkg::U_M_LAT: begin
				mul_a = {{2{latang_q[31]}}, latang_q};
				mul_b = gcdr_pkg::TURN_DEG;
			end
			gcdr_pkg::U_M_T3:  begin mul_a = st_q; mul_b = sd_q; end
			gcdr_pkg::U_M_Y:   begin mul_a = t3_q; mul_b = c1_q; end
			gcdr_pkg::U_M_X:   begin mul_a = s1_q; mul_b = s2_q; end
			gcdr_pkg::U_M_LON: begin
				mul_a = {{2{nl_q[31]}}, nl_q};
				mul_b = gcdr_pkg::TURN_DEG;
			end
			gcdr_pkg::U_M_ALT: begin
				mul_a = {{10{vs_q[23]}}, vs_q};
				mul_b = {18'b0, el_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start && is_mul) begin
			prod_s1 <= mul_a * mul_b;
		end
	end

	// degrees to turns, divided by the shared divider
	logic signed [31:0] turn_v;
	logic signed [41:0] turn_n;
	logic [41:0]        turn_mag;
	logic [38:0]        div_operand;
	logic [127:0]       div_recip;
	logic [31:0]        div_quo, div_res;
	logic               div_done;

	assign turn_v   = (cmd.op == gcdr_pkg::U_DIV_TLAT) ? {pos_lat_q[30], pos_lat_q} : pos_lon_q;
	assign turn_n   = {{3{turn_v[31]}}, turn_v, 7'b0} + gcdr_pkg::TURN_BIAS;
	assign turn_mag = turn_n[41] ? 42'(42'sd89 - turn_n) : turn_n;

	always_comb begin
		if (cmd.op == gcdr_pkg::U_DIV_DIST) begin
			div_operand = dist_q;
			div_recip   = DIST_RECIP;
		end else begin
			div_operand = turn_mag[38:0];
			div_recip   = gcdr_pkg::TURN_RECIP;
		end
	end

	assign div_res = div_neg_q ? -div_quo : div_quo;

	gcdr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start && is_div),
		.operand (div_operand),
		.recip   (div_recip),
		.quo     (div_quo),
		.done    (div_done)
	);

	// CORDIC operand selection
	logic [31:0]        cor_ang, cor_angle;
	logic signed [35:0] cor_x, cor_y, cor_sin, cor_cos;
	logic               cor_vec, cor_done;

	always_comb begin
		cor_ang = tlat_q;
		cor_vec = 1'b0;
		cor_x   = 36'(c2_q);
		cor_y   = 36'(s2_q);
		unique case (cmd.op)
			gcdr_pkg::U_COR_D:   cor_ang = delta_q;
			gcdr_pkg::U_COR_H:   cor_ang = {hd_q, 16'b0};
			gcdr_pkg::U_VEC_LAT: cor_vec = 1'b1;
			gcdr_pkg::U_VEC_LON: begin
				cor_vec = 1'b1;
				cor_x   = 36'(xv_q);
				cor_y   = 36'(yv_q);
			end
			default: ;
		endcase
	end

	gcdr_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start && is_cor),
		.vec    (cor_vec),
		.ang    (cor_ang),
		.xin    (cor_x),
		.yin    (cor_y),
		.sin_o  (cor_sin),
		.cos_o  (cor_cos),
		.angle  (cor_angle),
		.done   (cor_done)
	);

	// integer square root, computed bit by bit by shift and subtract
	logic [63:0] sq_v_q, sq_res_q, sq_bit_q, sq_sum;
	logic [4:0]  sq_cnt_q;
	logic        sq_busy_q, sq_done_q;

	assign sq_sum = sq_res_q + sq_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q  <= 1'b0;
			sq_done_q  <= 1'b0;
			sq_cnt_q   <= '0;
			mul_done_q <= 1'b0;
		end else begin
			sq_done_q  <= 1'b0;
			mul_done_q <= cmd.start && is_mul;
			if (cmd.start && cmd.op == gcdr_pkg::U_SQRT) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q  <= '0;
			end else if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q + 5'd1;
				if (sq_cnt_q == 5'd31) begin
					sq_busy_q <= 1'b0;
					sq_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && cmd.op == gcdr_pkg::U_SQRT) begin
			sq_v_q   <= {3'b0, sqv_q};
			sq_res_q <= '0;
			sq_bit_q <= 64'h4000_0000_0000_0000;
		end else if (sq_busy_q) begin
			if (sq_v_q >= sq_sum) begin
				sq_v_q   <= sq_v_q - sq_sum;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// writeback arithmetic on the registered product
	logic signed [67:0] q30, turned, sq_rem;
	logic signed [35:0] s2_sum, s2_clamp;
	logic signed [67:0] lat_clamp;
	logic signed [41:0] alt_sum;
	logic signed [31:0] alt_sat;

	always_comb begin
		q30      = prod_s1 >>> 30;
		turned   = (prod_s1 + 68'sd256) >>> 9;
		sq_rem   = (68'sd1 <<< 60) - prod_s1;
		s2_sum   = 36'(t1_q) + 36'(q30);
		s2_clamp = s2_sum;
		if (s2_sum > gcdr_pkg::ONE_Q30) begin
			s2_clamp = gcdr_pkg::ONE_Q30;
		end else if (s2_sum < -gcdr_pkg::ONE_Q30) begin
			s2_clamp = -gcdr_pkg::ONE_Q30;
		end
		lat_clamp = turned;
		if (turned > 68'(gcdr_pkg::LAT_LIMIT)) begin
			lat_clamp = 68'(gcdr_pkg::LAT_LIMIT);
		end else if (turned < -68'(gcdr_pkg::LAT_LIMIT)) begin
			lat_clamp = -68'(gcdr_pkg::LAT_LIMIT);
		end
		alt_sum = 42'(pos_alt_q) + 42'(prod_s1);
		alt_sat = 32'(alt_sum);
		if (alt_sum > 42'sh0_7FFF_FFFF) begin
			alt_sat = 32'sh7FFF_FFFF;
		end else if (alt_sum < -42'sh0_8000_0000) begin
			alt_sat = 32'sh8000_0000;
		end
	end

	// position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_lat_q <= '0;
			pos_lon_q <= '0;
			pos_alt_q <= '0;
			action_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				action_q <= action;
				if (action) begin
					pos_lat_q <= set_latitude;
					pos_lon_q <= set_longitude;
					pos_alt_q <= set_altitude;
				end
			end
			if (mul_done_q) begin
				unique case (cmd.op)
					gcdr_pkg::U_M_LAT: pos_lat_q <= 31'(lat_clamp);
					gcdr_pkg::U_M_LON: pos_lon_q <= 32'(turned);
					gcdr_pkg::U_M_ALT: pos_alt_q <= alt_sat;
					default: ;
				endcase
			end
		end
	end

	// item and intermediate registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gs_q <= ground_speed;
			vs_q <= vertical_speed;
			hd_q <= heading;
			el_q <= elapsed_seconds;
		end
		if (cmd.start && is_div) begin
			div_neg_q <= (cmd.op == gcdr_pkg::U_DIV_DIST) ? gs_q[23] : turn_n[41];
		end
		if (div_done) begin
			unique case (cmd.op)
				gcdr_pkg::U_DIV_DIST: delta_q <= div_res;
				gcdr_pkg::U_DIV_TLAT: tlat_q  <= div_res;
				default:              tlon_q  <= div_res;
			endcase
		end
		if (cor_done) begin
			unique case (cmd.op)
				gcdr_pkg::U_COR_LAT: begin s1_q <= 34'(cor_sin); c1_q <= 34'(cor_cos); end
				gcdr_pkg::U_COR_D:   begin sd_q <= 34'(cor_sin); cd_q <= 34'(cor_cos); end
				gcdr_pkg::U_COR_H:   begin st_q <= 34'(cor_sin); ct_q <= 34'(cor_cos); end
				gcdr_pkg::U_VEC_LAT: latang_q <= cor_angle;
				default:             nl_q <= tlon_q + cor_angle;
			endcase
		end
		if (sq_done_q) begin
			c2_q <= 34'(sq_res_q);
		end
		if (mul_done_q) begin
			unique case (cmd.op)
				gcdr_pkg::U_M_DIST: dist_q <= prod_s1[38:0];
				gcdr_pkg::U_M_T1:   t1_q   <= 34'(q30);
				gcdr_pkg::U_M_T2:   t2_q   <= 34'(q30);
				gcdr_pkg::U_M_S2:   s2_q   <= 34'(s2_clamp);
				gcdr_pkg::U_M_SQ:   sqv_q  <= sq_rem[60:0];
				gcdr_pkg::U_M_T3:   t3_q   <= 34'(q30);
				gcdr_pkg::U_M_Y:    yv_q   <= 34'(q30);
				gcdr_pkg::U_M_X:    xv_q   <= 34'(36'(cd_q) - 36'(q30));
				default: ;
			endcase
		end
	end

	assign stat.load = action_q;
	assign stat.done = mul_done_q | div_done | cor_done | sq_done_q;

	assign latitude  = pos_lat_q;
	assign longitude = pos_lon_q;
	assign altitude  = pos_alt_q;

endmodule

[hw/rtl/gcdr_ctrl.sv]
// Controller: handshakes and the micro-op sequencer that steps the datapath.
// Depends on gcdr_pkg.
module gcdr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output gcdr_pkg::dp_cmd_t  cmd,
	input  gcdr_pkg::dp_stat_t stat
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_ISSUE = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [4:0] pc_q;

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = (state_q == S_OUT);
	assign cmd.capture = req_valid && req_ready;
	assign cmd.start   = (state_q == S_ISSUE);
	assign cmd.op      = gcdr_pkg::prog(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					pc_q    <= '0;
					state_q <= stat.load ? S_OUT : S_ISSUE;
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (stat.done) begin
						if (pc_q == gcdr_pkg::PROG_LAST) begin
							state_q <= S_OUT;
						end else begin
							pc_q    <= pc_q + 5'd1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_OUT: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/gcdr_checker.sv]
// Port-level checks for the dead reckoning core, bound to the top level.
// Depends on the top level's ports only.
module gcdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_action,
	input logic [30:0] req_set_latitude,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [30:0] rsp_latitude
);

	// hold the response until it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// one request in flight: never ready while a response is pending
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request ready while response pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request ready right after accept");

	// load requests answer with the loaded latitude
	a_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action |-> ##2
		(rsp_valid && rsp_latitude == $past(req_set_latitude, 2)))
		else $error("load response wrong");

endmodule

bind great_circle_dead_reckoning_core gcdr_checker u_gcdr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_action       (req.action),
	.req_set_latitude (req.set_latitude),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_latitude     (rsp.latitude)
);

[bench/tb.sv]
// Self-checking bench for great_circle_dead_reckoning_core: random and directed
// load/advance requests, an in-bench position tracker and a scoreboard.
// Depends on gcdr_pkg, gcdr_if and the core RTL.
module tb;

	typedef struct {
		logic               action;
		logic signed [23:0] ground_speed;
		logic signed [23:0] vertical_speed;
		logic [15:0]        heading;
		logic [15:0]        elapsed_seconds;
		logic signed [30:0] set_latitude;
		logic signed [31:0] set_longitude;
		logic signed [31:0] set_altitude;
	} nav_req_t;

	typedef struct {
		logic signed [30:0] latitude;
		logic signed [31:0] longitude;
		logic signed [31:0] altitude;
	} nav_fix_t;

	localparam logic ACT_ADVANCE = 1'b0;
	localparam logic ACT_LOAD    = 1'b1;
	localparam int   STEPS       = gcdr_pkg::CORDIC_STEPS_DEF;
	localparam longint RADIUS    = gcdr_pkg::SPHERE_RADIUS_M_DEF;
	localparam longint Q30       = 64'sd1073741824;
	localparam longint GAIN      = 64'sd652032874;
	localparam longint LAT_MAX   = 64'sd754974720;
	localparam int   STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gcdr_req_if req_if ();
	gcdr_rsp_if rsp_if ();

	great_circle_dead_reckoning_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always #2 clk = ~clk;

	// tracked position and the fixes still owed by the core
	longint   trk_lat, trk_lon, trk_alt;
	nav_fix_t fix_queue[$];

	int  errors = 0;
	int  checked = 0;
	int  n_loads = 0;
	int  n_advances = 0;
	bit  idle_on = 1'b1;
	int  hold_req = 0;
	int  quiet_cycles = 0;

	// ---------------------------------------------------------------------
	// Position tracker: fixed-point destination-point arithmetic
	// ---------------------------------------------------------------------
	function automatic longint as_s(input logic [31:0] a);
		return longint'($signed(a));
	endfunction

	function automatic longint mulq(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic logic [31:0] deg_to_turn(input longint v);
		longint n, q;
		n = v * 1024 + 360;
		q = n / 720;
		if ((n % 720) < 0) q = q - 1;
		return q[31:0];
	endfunction

	function automatic longint turn_to_deg(input longint t);
		return (t * 360 + 256) >>> 9;
	endfunction

	function automatic void rotate(input logic [31:0] ang, output longint s,
		output longint c);
		bit flip;
		longint z, x, y, dx, dy;
		flip = 1'b0;
		z = as_s(ang);
		x = GAIN;
		y = 0;
		// fold angles past a quarter turn back into range
		if (z > Q30 || z < -Q30) begin
			z = as_s(ang + 32'h8000_0000);
			flip = 1'b1;
		end
		for (int i = 0; i < STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(gcdr_pkg::arc_turn(5'(i)));
			end else begin
				x += dx; y -= dy; z += longint'(gcdr_pkg::arc_turn(5'(i)));
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		s = y;
		c = x;
	endfunction

	function automatic logic [31:0] bearing_of(input longint y0, input longint x0);
		logic [31:0] base;
		longint x, y, z, dx, dy;
		base = '0;
		x = x0;
		y = y0;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; base = 32'h8000_0000;
		end
		for (int i = 0; i < STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(gcdr_pkg::arc_turn(5'(i)));
			end else begin
				x -= dx; y += dy; z -= longint'(gcdr_pkg::arc_turn(5'(i)));
			end
		end
		return base + z[31:0];
	endfunction

	function automatic logic [63:0] root_of(input logic [63:0] v0);
		logic [63:0] v, r, b;
		v = v0;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void track_request(input nav_req_t r, output nav_fix_t f);
		longint gs, vs, el, s1, c1, sd, cd, st, ct, s2, c2, lat, y, x, alt;
		logic [63:0] num, den, rem, quo, mag;
		logic [31:0] arc, lon_t;
		if (r.action == ACT_LOAD) begin
			trk_lat = longint'(r.set_latitude);
			trk_lon = longint'(r.set_longitude);
			trk_alt = longint'(r.set_altitude);
		end else begin
			gs = longint'(r.ground_speed);
			vs = longint'(r.vertical_speed);
			el = longint'(r.elapsed_seconds);
			mag = (gs < 0) ? -gs : gs;
			num = (mag * el) << 22;
			den = gcdr_pkg::TWO_PI_Q30 * RADIUS;
			rem = num % den;
			quo = '0;
			// 32 fraction bits of the travelled arc, in turns
			for (int i = 0; i < 32; i++) begin
				rem <<= 1;
				quo <<= 1;
				if (rem >= den) begin
					rem -= den; quo[0] = 1'b1;
				end
			end
			arc = quo[31:0];
			if (gs < 0) arc = -arc;
			rotate(deg_to_turn(trk_lat), s1, c1);
			rotate(arc, sd, cd);
			rotate({r.heading, 16'h0}, st, ct);
			s2 = mulq(s1, cd) + mulq(mulq(c1, sd), ct);
			if (s2 > Q30) s2 = Q30;
			if (s2 < -Q30) s2 = -Q30;
			c2 = longint'(root_of(64'(Q30 * Q30 - s2 * s2)));
			lat = turn_to_deg(as_s(bearing_of(s2, c2)));
			if (lat > LAT_MAX) lat = LAT_MAX;
			if (lat < -LAT_MAX) lat = -LAT_MAX;
			y = mulq(mulq(st, sd), c1);
			x = cd - mulq(s1, s2);
			lon_t = deg_to_turn(trk_lon) + bearing_of(y, x);
			alt = trk_alt + vs * el;
			if (alt > 64'sd2147483647) alt = 64'sd2147483647;
			if (alt < -64'sd2147483648) alt = -64'sd2147483648;
			trk_lat = lat;
			trk_lon = turn_to_deg(as_s(lon_t));
			trk_alt = alt;
		end
		f.latitude  = trk_lat[30:0];
		f.longitude = trk_lon[31:0];
		f.altitude  = trk_alt[31:0];
	endfunction

	// ---------------------------------------------------------------------
	// Request side: drive at the falling edge, accept at the rising edge
	// ---------------------------------------------------------------------
	task automatic send_request(input nav_req_t r);
		nav_fix_t f;
		int gap;
		@(negedge clk);
		// random idle burst before the request
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_if.valid = 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(negedge clk);
		end
		req_if.action          = r.action;
		req_if.ground_speed    = r.ground_speed;
		req_if.vertical_speed  = r.vertical_speed;
		req_if.heading         = r.heading;
		req_if.elapsed_seconds = r.elapsed_seconds;
		req_if.set_latitude    = r.set_latitude;
		req_if.set_longitude   = r.set_longitude;
		req_if.set_altitude    = r.set_altitude;
		req_if.valid           = 1'b1;
		do @(posedge clk); while (!req_if.ready);
		track_request(r, f);
		fix_queue.push_back(f);
		if (r.action == ACT_LOAD) n_loads++;
		else n_advances++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		req_if.valid = 1'b0;
	endtask

	function automatic nav_req_t noise_req();
		nav_req_t r;
		r.action          = $urandom_range(0, 1);
		r.ground_speed    = $urandom;
		r.vertical_speed  = $urandom;
		r.heading         = $urandom;
		r.elapsed_seconds = $urandom;
		r.set_latitude    = $urandom;
		r.set_longitude   = $urandom;
		r.set_altitude    = $urandom;
		return r;
	endfunction

	function automatic nav_req_t load_req(input longint lat, input longint lon,
		input longint alt);
		nav_req_t r;
		r = noise_req();
		r.action = ACT_LOAD;
		r.set_latitude = lat[30:0];
		r.set_longitude = lon[31:0];
		r.set_altitude = alt[31:0];
		return r;
	endfunction

	function automatic nav_req_t move_req(input longint gs, input longint vs,
		input int hd, input int el);
		nav_req_t r;
		r = noise_req();
		r.action = ACT_ADVANCE;
		r.ground_speed = gs[23:0];
		r.vertical_speed = vs[23:0];
		r.heading = hd[15:0];
		r.elapsed_seconds = el[15:0];
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Response side: random stalls plus a requested long hold-off
	// ---------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11);
			end
			if (stall_left > 0) begin
				rsp_if.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready = 1'b1;
			end
		end
	end

	task automatic report_mismatch(input string what, input longint got,
		input longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d (fix %0d)", what, got, want, checked);
	endtask

	// scoreboard: compare each taken fix with the oldest expectation
	always @(posedge clk) begin
		nav_fix_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (fix_queue.size() == 0) begin
				report_mismatch("unexpected response, latitude", rsp_if.latitude, 0);
			end else begin
				want = fix_queue.pop_front();
				if (rsp_if.latitude !== want.latitude)
					report_mismatch("latitude", rsp_if.latitude, want.latitude);
				if (rsp_if.longitude !== want.longitude)
					report_mismatch("longitude", rsp_if.longitude, want.longitude);
				if (rsp_if.altitude !== want.altitude)
					report_mismatch("altitude", rsp_if.altitude, want.altitude);
			end
			checked++;
		end
	end

	// watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	task automatic test_extremes();
		// loads at the field limits, including out-of-range latitudes
		send_request(load_req(LAT_MAX, -64'sd1509949440, -64'sd2147483648));
		send_request(load_req(-LAT_MAX, 64'sd1509949439, 64'sd2147483647));
		send_request(move_req(0, 0, 0, 0));
		send_request(load_req(-64'sd1073741824, 0, 0));
		send_request(move_req(64'sd100000, 0, 16384, 10));
		send_request(load_req(64'sd1073741823, 0, 0));
		send_request(move_req(0, 0, 32768, 1));
		// altitude saturation both ways
		send_request(load_req(0, 0, 64'sd2147483000));
		send_request(move_req(0, 64'sd8388607, 0, 65535));
		send_request(load_req(0, 0, -64'sd2147483000));
		send_request(move_req(0, -64'sd8388608, 0, 65535));
		// longitude wrap eastward and westward
		send_request(load_req(0, 64'sd1509900000, 0));
		send_request(move_req(64'sd8388607, 0, 16384, 60));
		send_request(load_req(0, -64'sd1509900000, 0));
		send_request(move_req(64'sd8388607, 0, 49152, 60));
		// pole crossing, full speed reverse, long spans
		send_request(load_req(64'sd754000000, 0, 0));
		send_request(move_req(64'sd8388607, 0, 0, 65535));
		send_request(move_req(-64'sd8388608, 64'sd1, 65535, 65535));
		send_request(move_req(-64'sd1, -64'sd1, 16384, 1));
		send_request(move_req(64'sd50000, 64'sd300, 8192, 3600));
		send_request(move_req(64'sd8388607, 64'sd8388607, 65535, 65535));
		send_request(move_req(64'sd0, 64'sd100, 40000, 65535));
	endtask

	task automatic test_random(input int count);
		nav_req_t r;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				r = load_req($signed($urandom_range(0, 1509949440)) - 64'sd754974720,
					longint'($signed($urandom)) % 64'sd1509949440, longint'($signed($urandom)));
				if (pick == 0) r.set_latitude = $urandom;
			end else if (pick < 9) begin
				r = move_req(longint'($signed(24'($urandom))) >>> $urandom_range(0, 12),
					longint'($signed(24'($urandom))) >>> $urandom_range(0, 12),
					$urandom_range(0, 65535), $urandom_range(0, 3600));
			end else begin
				r = noise_req();
			end
			send_request(r);
		end
	endtask

	task automatic test_backpressure();
		// hold the response side long enough for the core to stall its input
		@(negedge clk);
		hold_req = 600;
		for (int i = 0; i < 6; i++)
			send_request(move_req(64'sd20000, 64'sd20, $urandom_range(0, 65535), 30));
	endtask

	task automatic wait_drained();
		while (fix_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.action = ACT_ADVANCE;
		req_if.ground_speed = '0;
		req_if.vertical_speed = '0;
		req_if.heading = '0;
		req_if.elapsed_seconds = '0;
		req_if.set_latitude = '0;
		req_if.set_longitude = '0;
		req_if.set_altitude = '0;
		trk_lat = 0;
		trk_lon = 0;
		trk_alt = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_random(1800);
		test_backpressure();
		idle_on = 1'b0;
		test_random(150);
		drop_valid();
		wait_drained();

		$display("covered %0d load and %0d advance requests, %0d fixes checked",
			n_loads, n_advances, checked);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/gcdr_pkg.sv
hw/rtl/gcdr_if.sv
hw/rtl/gcdr_div.sv
hw/rtl/gcdr_cordic.sv
hw/rtl/gcdr_dp.sv
hw/rtl/gcdr_ctrl.sv
hw/rtl/great_circle_dead_reckoning_core.sv
hw/rtl/gcdr_checker.sv
bench/tb.sv
